@@ rtl/dvrt_pkg.sv @@
// Package: shared types, codes and helpers of the distance-vector route table.
package dvrt_pkg;

    localparam int DIST_W = 16;
    localparam logic [DIST_W-1:0] DIST_INF = '1;
    localparam logic [DIST_W-1:0] DIST_SAT = DIST_INF - 1'b1;

    localparam logic [1:0] LINK_SEEN    = 2'd0;
    localparam logic [1:0] LINK_UNSEEN  = 2'd1;
    localparam logic [1:0] LINK_UNREACH = 2'd2;

    localparam logic [2:0] KIND_ADV   = 3'd0;
    localparam logic [2:0] KIND_TICK  = 3'd1;
    localparam logic [2:0] KIND_QUERY = 3'd2;
    localparam logic [2:0] KIND_SEND  = 3'd3;
    localparam logic [2:0] KIND_SEED  = 3'd4;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_SELF    = 3'd1;
    localparam logic [2:0] STAT_NO_IF   = 3'd2;
    localparam logic [2:0] STAT_FULL    = 3'd3;
    localparam logic [2:0] STAT_BAD_IDX = 3'd4;

    localparam logic [2:0] REG_IF_COUNT = 3'd0;
    localparam logic [2:0] REG_IF0      = 3'd1;
    localparam logic [2:0] REG_IF1      = 3'd2;
    localparam logic [2:0] REG_IF2      = 3'd3;
    localparam logic [2:0] REG_IF3      = 3'd4;

    typedef struct packed {
        logic [31:0]       net;
        logic [5:0]        pfx;
        logic [DIST_W-1:0] metric;
        logic [31:0]       via;
    } route_t;

    typedef struct packed {
        logic [2:0]       iface_count;
        logic [3:0][53:0] iface;
    } dvrt_cfg_t;

    function automatic logic [5:0] clamp_pfx(input logic [5:0] p);
        return (p > 6'd32) ? 6'd32 : p;
    endfunction

    function automatic logic [31:0] pfx_mask(input logic [5:0] p);
        logic [31:0] m;
        m = '1;
        if (p == 6'd0)
            m = '0;
        else
            m = m << (6'd32 - p);
        return m;
    endfunction

endpackage

@@ rtl/dvrt_if.sv @@
// Interfaces: input item channel and result channel.
interface dvrt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] adv_network;
    logic [5:0]  adv_prefix;
    logic [15:0] adv_distance;
    logic [31:0] sender_address;
    logic [5:0]  entry_index;
    logic [1:0]  iface_index;
    logic        send_ok;

    modport source (output valid, kind, adv_network, adv_prefix, adv_distance,
                    sender_address, entry_index, iface_index, send_ok, input ready);
    modport sink (input valid, kind, adv_network, adv_prefix, adv_distance,
                  sender_address, entry_index, iface_index, send_ok, output ready);
endinterface

interface dvrt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        suppress;
    logic [31:0] out_network;
    logic [5:0]  out_prefix;
    logic [15:0] out_distance;
    logic [31:0] out_via;
    logic [6:0]  route_count;

    modport source (output valid, status, suppress, out_network, out_prefix,
                    out_distance, out_via, route_count, input ready);
    modport sink (input valid, status, suppress, out_network, out_prefix,
                  out_distance, out_via, route_count, output ready);
endinterface

@@ rtl/distance_vector_route_table_unit.sv @@
// Top level: distance-vector route table with a one-write, one-read route memory and scan sequencer.
//
//  channel   dir  handshake        beat contents
//  in_ch     in   valid/ready      kind, advertised route, sender, entry/iface index, send_ok
//  out_ch    out  valid/ready      status, suppress, queried entry, route_count
//  apb       in   psel/penable     iface_count at byte address 0, iface0..3_entry at 8*(i+1)
//
// A seed makes one memory write per interface; an advertisement, a round tick and a
// failed send report scan the table. Every scan reads each entry from the route
// memory (registered read) in S_RD, then modifies and writes it back in S_MOD.
// Reset clears the entry count and the link states; the memory contents stay
// undefined and are never read above the entry count. A result waits in the output
// register while the next beat is taken; a new result is held in the done state
// until the output register is free.
module distance_vector_route_table_unit
#(
    parameter int TABLE_DEPTH = 64,
    parameter int MAX_IFACES  = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    dvrt_in_if.sink     in_ch,
    dvrt_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = (CW > 6) ? CW : 6;
    localparam int IW = (MAX_IFACES > 1) ? $clog2(MAX_IFACES) : 1;
    localparam int DW = dvrt_pkg::DIST_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_ADVWR = 3'd3;
    localparam logic [2:0] S_IFACE = 3'd4;
    localparam logic [2:0] S_SEED  = 3'd5;
    localparam logic [2:0] S_QRY   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    dvrt_pkg::dvrt_cfg_t cfg;

    dvrt_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Route memory: one write and one registered read a cycle.
    dvrt_pkg::route_t mem [TABLE_DEPTH];
    dvrt_pkg::route_t rd_reg;
    dvrt_pkg::route_t wd;
    logic [AW-1:0]    ra, wa;
    logic             re, we;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (re)
            rd_reg <= mem[ra];
    end

    // Control and item registers.
    logic [2:0]    state_reg, state_next;
    logic [2:0]    op_reg, op_next;
    logic [CW-1:0] j_reg, j_next;
    logic [1:0]    ic_reg, ic_next;
    logic [1:0]    last_reg, last_next;
    logic [CW-1:0] valid_reg, valid_next;
    logic [1:0]    link_reg [MAX_IFACES];
    logic [1:0]    link_next [MAX_IFACES];
    logic [31:0]   anet_reg, anet_next;
    logic [5:0]    apfx_reg, apfx_next;
    logic [DW-1:0] adist_reg, adist_next;
    logic [31:0]   sender_reg, sender_next;
    logic [DW-1:0] cost_reg, cost_next;
    logic          force_reg, force_next;
    logic          match_reg, match_next;
    logic [AW-1:0] midx_reg, midx_next;
    logic [DW-1:0] mdist_reg, mdist_next;
    logic [2:0]    rstat_reg, rstat_next;
    logic          rsup_reg, rsup_next;
    dvrt_pkg::route_t rent_reg, rent_next;
    logic          ovalid_reg, ovalid_next;
    logic [2:0]    ostat_reg, ostat_next;
    logic          osup_reg, osup_next;
    dvrt_pkg::route_t oent_reg, oent_next;
    logic [6:0]    ocount_reg, ocount_next;

    // Interface count in use and the selected interface's fields.
    logic [2:0]    n_used;
    logic [53:0]   sel_if;
    logic [31:0]   sel_addr, sel_mask, sel_net;
    logic [5:0]    sel_pfx;
    logic [DW-1:0] sel_cost;

    assign n_used   = (cfg.iface_count > 3'(MAX_IFACES)) ? 3'(MAX_IFACES) : cfg.iface_count;
    assign sel_if   = cfg.iface[ic_reg];
    assign sel_addr = sel_if[31:0];
    assign sel_pfx  = dvrt_pkg::clamp_pfx(sel_if[37:32]);
    assign sel_cost = sel_if[53:38];
    assign sel_mask = dvrt_pkg::pfx_mask(sel_pfx);
    assign sel_net  = sel_addr & sel_mask;

    // Sender checks across the interfaces of an incoming advertisement.
    logic             adv_self, adv_have;
    logic [1:0]       adv_sid;
    logic [MAX_IFACES-1:0] adv_seen;

    always_comb
    begin
        logic [31:0] m;
        adv_self = 1'b0;
        adv_have = 1'b0;
        adv_sid  = 2'd0;
        adv_seen = '0;
        for (int i = 0; i < MAX_IFACES; i++)
        begin
            m = dvrt_pkg::pfx_mask(dvrt_pkg::clamp_pfx(cfg.iface[i][37:32]));
            if (3'(i) < n_used)
            begin
                if (cfg.iface[i][31:0] == in_ch.sender_address)
                    adv_self = 1'b1;
                if ((in_ch.sender_address & m) == (cfg.iface[i][31:0] & m))
                begin
                    adv_seen[i] = 1'b1;
                    adv_have    = 1'b1;
                    adv_sid     = 2'(i);
                end
            end
        end
    end

    // Per-entry terms on the word just read.
    logic [31:0]   rd_mask, rd_net, via_raw, via_m;
    logic [DW:0]   sum_w;
    logic [DW-1:0] sum_sat;
    logic          adv_usable;
    logic [1:0]    f_in;
    logic          accept, out_free;

    assign rd_mask    = dvrt_pkg::pfx_mask(rd_reg.pfx);
    assign rd_net     = rd_reg.net & rd_mask;
    assign via_raw    = (rd_reg.via == 32'd0) ? rd_reg.net : rd_reg.via;
    assign via_m      = via_raw & sel_mask;
    assign sum_w      = {1'b0, adist_reg} + {1'b0, cost_reg};
    assign sum_sat    = (sum_w > {1'b0, dvrt_pkg::DIST_SAT}) ? dvrt_pkg::DIST_SAT : sum_w[DW-1:0];
    assign adv_usable = (adist_reg != dvrt_pkg::DIST_INF) && (cost_reg != dvrt_pkg::DIST_INF);
    assign f_in       = in_ch.iface_index;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept     = in_ch.valid && in_ch.ready;
    assign out_free   = !ovalid_reg || out_ch.ready;

    always_comb
    begin
        logic [5:0]  ap;
        logic [31:0] am;
        logic        last_entry;
        state_next  = state_reg;
        op_next     = op_reg;
        j_next      = j_reg;
        ic_next     = ic_reg;
        last_next   = last_reg;
        valid_next  = valid_reg;
        link_next   = link_reg;
        anet_next   = anet_reg;
        apfx_next   = apfx_reg;
        adist_next  = adist_reg;
        sender_next = sender_reg;
        cost_next   = cost_reg;
        force_next  = force_reg;
        match_next  = match_reg;
        midx_next   = midx_reg;
        mdist_next  = mdist_reg;
        rstat_next  = rstat_reg;
        rsup_next   = rsup_reg;
        rent_next   = rent_reg;
        ovalid_next = ovalid_reg;
        ostat_next  = ostat_reg;
        osup_next   = osup_reg;
        oent_next   = oent_reg;
        ocount_next = ocount_reg;
        re = 1'b0;
        ra = j_reg[AW-1:0];
        we = 1'b0;
        wa = j_reg[AW-1:0];
        wd = rd_reg;
        ap = dvrt_pkg::clamp_pfx(apfx_reg);
        am = dvrt_pkg::pfx_mask(ap);
        last_entry = ((j_reg + 1'b1) == valid_reg);

        if (ovalid_reg && out_ch.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = in_ch.kind;
                    rstat_next  = dvrt_pkg::STAT_OK;
                    rsup_next   = 1'b0;
                    rent_next   = '0;
                    j_next      = '0;
                    anet_next   = in_ch.adv_network;
                    apfx_next   = dvrt_pkg::clamp_pfx(in_ch.adv_prefix);
                    adist_next  = in_ch.adv_distance;
                    sender_next = in_ch.sender_address;
                    force_next  = 1'b0;
                    match_next  = 1'b0;
                    state_next  = S_DONE;
                    case (in_ch.kind)
                        dvrt_pkg::KIND_ADV:
                        begin
                            if (adv_self)
                                rstat_next = dvrt_pkg::STAT_SELF;
                            else if (!adv_have)
                                rstat_next = dvrt_pkg::STAT_NO_IF;
                            else
                            begin
                                for (int i = 0; i < MAX_IFACES; i++)
                                    if (adv_seen[i])
                                        link_next[i] = dvrt_pkg::LINK_SEEN;
                                cost_next  = cfg.iface[adv_sid][53:38];
                                state_next = (valid_reg == '0) ? S_ADVWR : S_RD;
                            end
                        end
                        dvrt_pkg::KIND_TICK:
                        begin
                            ic_next = 2'd0;
                            if (n_used != 3'd0)
                                state_next = S_IFACE;
                        end
                        dvrt_pkg::KIND_QUERY:
                        begin
                            ic_next = f_in;
                            if ((EW'(in_ch.entry_index) >= EW'(valid_reg)) ||
                                ({1'b0, f_in} >= n_used))
                                rstat_next = dvrt_pkg::STAT_BAD_IDX;
                            else
                            begin
                                re         = 1'b1;
                                ra         = AW'(in_ch.entry_index);
                                state_next = S_QRY;
                            end
                        end
                        dvrt_pkg::KIND_SEND:
                        begin
                            ic_next = f_in;
                            if ({1'b0, f_in} >= n_used)
                                rstat_next = dvrt_pkg::STAT_BAD_IDX;
                            else if (in_ch.send_ok)
                            begin
                                if (link_reg[IW'(f_in)] == dvrt_pkg::LINK_UNREACH)
                                    link_next[IW'(f_in)] = dvrt_pkg::LINK_UNSEEN;
                            end
                            else
                            begin
                                link_next[IW'(f_in)] = dvrt_pkg::LINK_UNREACH;
                                if (valid_reg != '0)
                                    state_next = S_RD;
                            end
                        end
                        dvrt_pkg::KIND_SEED:
                        begin
                            valid_next = '0;
                            for (int i = 0; i < MAX_IFACES; i++)
                                link_next[i] = dvrt_pkg::LINK_UNSEEN;
                            ic_next = 2'd0;
                            if (n_used != 3'd0)
                                state_next = S_SEED;
                        end
                        default: ;
                    endcase
                end
            end

            S_SEED:
            begin
                we        = 1'b1;
                wa        = AW'(ic_reg);
                wd.net    = sel_addr;
                wd.pfx    = sel_pfx;
                wd.metric = sel_cost;
                wd.via    = 32'd0;
                ic_next   = ic_reg + 2'd1;
                if (({1'b0, ic_reg} + 3'd1) == n_used)
                begin
                    valid_next = CW'(n_used);
                    state_next = S_DONE;
                end
            end

            S_IFACE:
            begin
                last_next = link_reg[IW'(ic_reg)];
                if (link_reg[IW'(ic_reg)] == dvrt_pkg::LINK_SEEN)
                    link_next[IW'(ic_reg)] = dvrt_pkg::LINK_UNSEEN;
                j_next = '0;
                if (valid_reg != '0)
                    state_next = S_RD;
                else if (({1'b0, ic_reg} + 3'd1) >= n_used)
                    state_next = S_DONE;
                else
                    ic_next = ic_reg + 2'd1;
            end

            S_RD:
            begin
                re         = 1'b1;
                state_next = S_MOD;
            end

            S_MOD:
            begin
                j_next     = j_reg + 1'b1;
                state_next = S_RD;
                case (op_reg)
                    dvrt_pkg::KIND_ADV:
                    begin
                        if (rd_net == (anet_reg & am))
                        begin
                            if (rd_reg.via == sender_reg && adist_reg == dvrt_pkg::DIST_INF)
                                force_next = 1'b1;
                            if (rd_reg.pfx == ap)
                            begin
                                match_next = 1'b1;
                                midx_next  = j_reg[AW-1:0];
                                mdist_next = rd_reg.metric;
                            end
                        end
                        if (last_entry)
                            state_next = S_ADVWR;
                    end
                    dvrt_pkg::KIND_TICK:
                    begin
                        if (sel_net == rd_net && sel_pfx == rd_reg.pfx &&
                            sel_cost < rd_reg.metric)
                        begin
                            if (last_reg != dvrt_pkg::LINK_UNREACH)
                            begin
                                we        = 1'b1;
                                wd.net    = sel_addr;
                                wd.pfx    = sel_pfx;
                                wd.metric = sel_cost;
                                wd.via    = 32'd0;
                            end
                            else if (rd_reg.metric == dvrt_pkg::DIST_INF)
                            begin
                                we     = 1'b1;
                                wd.via = 32'd0;
                            end
                        end
                        else if (via_m != (rd_reg.net & sel_mask) && via_m == sel_net &&
                                 last_reg != dvrt_pkg::LINK_SEEN)
                        begin
                            we        = 1'b1;
                            wd.metric = dvrt_pkg::DIST_INF;
                        end
                        if (last_entry)
                        begin
                            if (({1'b0, ic_reg} + 3'd1) >= n_used)
                                state_next = S_DONE;
                            else
                            begin
                                ic_next    = ic_reg + 2'd1;
                                state_next = S_IFACE;
                            end
                        end
                    end
                    default:
                    begin
                        // failed send: poison direct routes on this interface's net
                        if (rd_reg.via == 32'd0 && rd_net == sel_net)
                        begin
                            we        = 1'b1;
                            wd.metric = dvrt_pkg::DIST_INF;
                        end
                        if (last_entry)
                            state_next = S_DONE;
                    end
                endcase
            end

            S_ADVWR:
            begin
                wd.net = anet_reg;
                wd.pfx = ap;
                wd.via = sender_reg;
                wa     = midx_reg;
                if (match_reg)
                begin
                    if (adv_usable && sum_sat < mdist_reg)
                    begin
                        we        = 1'b1;
                        wd.metric = sum_sat;
                    end
                    else if (force_reg)
                    begin
                        we        = 1'b1;
                        wd.metric = adist_reg;
                    end
                end
                else if (adv_usable)
                begin
                    if (valid_reg >= CW'(TABLE_DEPTH))
                        rstat_next = dvrt_pkg::STAT_FULL;
                    else
                    begin
                        we         = 1'b1;
                        wa         = valid_reg[AW-1:0];
                        wd.metric  = sum_sat;
                        valid_next = valid_reg + 1'b1;
                    end
                end
                state_next = S_DONE;
            end

            S_QRY:
            begin
                rsup_next  = ((rd_reg.via & sel_mask) == sel_net);
                rent_next  = rd_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = rstat_reg;
                    osup_next   = rsup_reg;
                    oent_next   = rent_reg;
                    ocount_next = 7'(valid_reg);
                    state_next  = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < MAX_IFACES; i++)
                link_reg[i] <= dvrt_pkg::LINK_UNSEEN;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            ovalid_reg <= ovalid_next;
            link_reg   <= link_next;
        end
    end

    // Payload and scan registers: no reset needed.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        j_reg      <= j_next;
        ic_reg     <= ic_next;
        last_reg   <= last_next;
        anet_reg   <= anet_next;
        apfx_reg   <= apfx_next;
        adist_reg  <= adist_next;
        sender_reg <= sender_next;
        cost_reg   <= cost_next;
        force_reg  <= force_next;
        match_reg  <= match_next;
        midx_reg   <= midx_next;
        mdist_reg  <= mdist_next;
        rstat_reg  <= rstat_next;
        rsup_reg   <= rsup_next;
        rent_reg   <= rent_next;
        ostat_reg  <= ostat_next;
        osup_reg   <= osup_next;
        oent_reg   <= oent_next;
        ocount_reg <= ocount_next;
    end

    assign out_ch.valid        = ovalid_reg;
    assign out_ch.status       = ostat_reg;
    assign out_ch.suppress     = osup_reg;
    assign out_ch.out_network  = oent_reg.net;
    assign out_ch.out_prefix   = oent_reg.pfx;
    assign out_ch.out_distance = oent_reg.metric;
    assign out_ch.out_via      = oent_reg.via;
    assign out_ch.route_count  = ocount_reg;

    // The entry count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg <= CW'(TABLE_DEPTH))
        else $error("route count above table depth");

    // No memory write while waiting for a beat.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !we)
        else $error("route memory written while idle");

    // A bad-index result, from a query or a send report, carries no entry.
    a_bad_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && ostat_reg == dvrt_pkg::STAT_BAD_IDX) |->
            (oent_reg.net == 32'd0 && oent_reg.metric == '0 && !osup_reg))
        else $error("bad index result carries entry data");

endmodule

@@ rtl/dvrt_cfg.sv @@
// APB register file holding the interface count and the four interface entries.
module dvrt_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output dvrt_pkg::dvrt_cfg_t cfg
);

    logic [2:0]       count_reg;
    logic [3:0][53:0] iface_reg;
    logic [2:0]       idx;
    logic             wr;

    assign idx    = paddr[5:3];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd1;
            iface_reg <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                dvrt_pkg::REG_IF_COUNT: count_reg    <= pwdata[2:0];
                dvrt_pkg::REG_IF0:      iface_reg[0] <= pwdata[53:0];
                dvrt_pkg::REG_IF1:      iface_reg[1] <= pwdata[53:0];
                dvrt_pkg::REG_IF2:      iface_reg[2] <= pwdata[53:0];
                dvrt_pkg::REG_IF3:      iface_reg[3] <= pwdata[53:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            dvrt_pkg::REG_IF_COUNT: prdata = {61'd0, count_reg};
            dvrt_pkg::REG_IF0:      prdata = {10'd0, iface_reg[0]};
            dvrt_pkg::REG_IF1:      prdata = {10'd0, iface_reg[1]};
            dvrt_pkg::REG_IF2:      prdata = {10'd0, iface_reg[2]};
            dvrt_pkg::REG_IF3:      prdata = {10'd0, iface_reg[3]};
            default:                prdata = '0;
        endcase
    end

    assign cfg.iface_count = count_reg;
    assign cfg.iface       = iface_reg;

endmodule

@@ test/tb_distance_vector_route_table_unit.sv @@
// Testbench: randomised and directed check of the distance-vector route table unit.
module tb_distance_vector_route_table_unit;

    timeunit 1ns;
    timeprecision 1ps;

    // Allow for the longest scan (a round tick over a full table on four
    // interfaces), the long receiver hold and the worst output stall, many times over.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int NUM_ROUTES     = 64;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] network;
        logic [5:0]  prefix;
        logic [15:0] distance;
        logic [31:0] sender;
        logic [5:0]  entry;
        logic [1:0]  iface;
        logic        ok;
    } route_item_t;

    typedef struct {
        logic [2:0]  status;
        logic        suppress;
        logic [31:0] network;
        logic [5:0]  prefix;
        logic [15:0] distance;
        logic [31:0] via;
        logic [6:0]  count;
    } route_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    dvrt_in_if  in_if ();
    dvrt_out_if out_if ();

    distance_vector_route_table_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the table, link states and registers.
    logic [31:0] shadow_net  [NUM_ROUTES];
    logic [5:0]  shadow_pfx  [NUM_ROUTES];
    logic [15:0] shadow_dist [NUM_ROUTES];
    logic [31:0] shadow_via  [NUM_ROUTES];
    int unsigned shadow_count;
    logic [1:0]  shadow_link [4];
    logic [2:0]  cfg_count;
    logic [53:0] cfg_iface [4];

    route_item_t   item_queue[$];
    route_result_t awaited_results[$];

    int unsigned in_beats;
    int unsigned out_beats;
    int unsigned drv_seen;
    int unsigned rcv_seen;
    int unsigned in_gap;
    int unsigned out_stall;
    int unsigned hold_left;
    int unsigned hold_req;
    int unsigned hold_done;
    int unsigned idle_cycles;
    int unsigned errors;
    int unsigned kind_seen [8];
    int unsigned full_hits;
    int unsigned suppress_hits;
    bit          gap_free;

    // ------------------------------------------------------------------
    // Prediction helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] masked(input logic [31:0] a, input logic [5:0] p);
        if (p == 6'd0)
            return 32'd0;
        return a & (32'hFFFF_FFFF << (32 - int'(p)));
    endfunction

    function automatic logic [5:0] limit_pfx(input logic [5:0] p);
        return (p > 6'd32) ? 6'd32 : p;
    endfunction

    function automatic int unsigned ifaces_in_use();
        return (cfg_count > 3'd4) ? 4 : int'(cfg_count);
    endfunction

    function automatic logic [31:0] iface_addr(input int i);
        return cfg_iface[i][31:0];
    endfunction

    function automatic logic [5:0] iface_pfx(input int i);
        return limit_pfx(cfg_iface[i][37:32]);
    endfunction

    function automatic logic [15:0] iface_cost(input int i);
        return cfg_iface[i][53:38];
    endfunction

    function automatic void store_route(input int k, input logic [31:0] net,
                                        input logic [5:0] pfx, input logic [15:0] dist_v,
                                        input logic [31:0] via);
        shadow_net[k]  = net;
        shadow_pfx[k]  = pfx;
        shadow_dist[k] = dist_v;
        shadow_via[k]  = via;
    endfunction

    // Advertisement: drop self-sent, mark arrival interfaces seen, then relax,
    // append or poison.
    function automatic logic [2:0] learn_advert(input route_item_t it);
        int unsigned n;
        int          sid;
        int          hit;
        bit          force_inf;
        logic [5:0]  apfx;
        logic [31:0] anet_m;
        logic [15:0] cost;
        logic [16:0] total;
        bit          same;
        n         = ifaces_in_use();
        sid       = -1;
        hit       = -1;
        force_inf = 0;
        apfx      = limit_pfx(it.prefix);
        anet_m    = masked(it.network, apfx);
        for (int i = 0; i < n; i++)
            if (iface_addr(i) == it.sender)
                return dvrt_pkg::STAT_SELF;
        for (int i = 0; i < n; i++)
            if (masked(it.sender, iface_pfx(i)) == masked(iface_addr(i), iface_pfx(i)))
            begin
                shadow_link[i] = dvrt_pkg::LINK_SEEN;
                sid = i;
            end
        if (sid < 0)
            return dvrt_pkg::STAT_NO_IF;
        for (int j = 0; j < shadow_count; j++)
        begin
            same = masked(shadow_net[j], shadow_pfx[j]) == anet_m;
            if (same && shadow_via[j] == it.sender && it.distance == dvrt_pkg::DIST_INF)
                force_inf = 1;
            if (same && shadow_pfx[j] == apfx)
                hit = j;
        end
        cost  = iface_cost(sid);
        total = {1'b0, it.distance} + {1'b0, cost};
        if (total > {1'b0, dvrt_pkg::DIST_SAT})
            total = {1'b0, dvrt_pkg::DIST_SAT};
        if (hit >= 0)
        begin
            if (it.distance != dvrt_pkg::DIST_INF && cost != dvrt_pkg::DIST_INF &&
                total < {1'b0, shadow_dist[hit]})
                store_route(hit, it.network, apfx, total[15:0], it.sender);
            else if (force_inf)
                store_route(hit, it.network, apfx, it.distance, it.sender);
        end
        else if (it.distance != dvrt_pkg::DIST_INF && cost != dvrt_pkg::DIST_INF)
        begin
            if (shadow_count >= NUM_ROUTES)
                return dvrt_pkg::STAT_FULL;
            store_route(shadow_count, it.network, apfx, total[15:0], it.sender);
            shadow_count++;
        end
        return dvrt_pkg::STAT_OK;
    endfunction

    // Round tick: age links, reinstate better direct routes, poison routes
    // learned on silent links.
    function automatic void age_links();
        logic [1:0]  last;
        logic [5:0]  dpfx;
        logic [31:0] daddr;
        logic [31:0] dnet;
        logic [15:0] dcost;
        logic [31:0] hop;
        for (int i = 0; i < ifaces_in_use(); i++)
        begin
            last  = shadow_link[i];
            dpfx  = iface_pfx(i);
            daddr = iface_addr(i);
            dnet  = masked(daddr, dpfx);
            dcost = iface_cost(i);
            if (last == dvrt_pkg::LINK_SEEN)
                shadow_link[i] = dvrt_pkg::LINK_UNSEEN;
            for (int j = 0; j < shadow_count; j++)
            begin
                hop = (shadow_via[j] == 32'd0) ? shadow_net[j] : shadow_via[j];
                hop = masked(hop, dpfx);
                if (dnet == masked(shadow_net[j], shadow_pfx[j]) && dpfx == shadow_pfx[j]
                    && dcost < shadow_dist[j])
                begin
                    if (last != dvrt_pkg::LINK_UNREACH)
                        store_route(j, daddr, dpfx, dcost, 32'd0);
                    else if (shadow_dist[j] == dvrt_pkg::DIST_INF)
                        shadow_via[j] = 32'd0;
                end
                else if (hop != masked(shadow_net[j], dpfx) && hop == dnet
                         && last != dvrt_pkg::LINK_SEEN)
                    shadow_dist[j] = dvrt_pkg::DIST_INF;
            end
        end
    endfunction

    function automatic route_result_t apply_route_item(input route_item_t it);
        route_result_t r;
        int unsigned   n;
        logic [5:0]    p;
        logic [31:0]   dnet;
        r = '{default: '0};
        n = ifaces_in_use();
        case (it.kind)
            dvrt_pkg::KIND_ADV:
                r.status = learn_advert(it);
            dvrt_pkg::KIND_TICK:
                age_links();
            dvrt_pkg::KIND_QUERY:
                if (it.entry >= shadow_count || it.iface >= n)
                    r.status = dvrt_pkg::STAT_BAD_IDX;
                else
                begin
                    p = iface_pfx(it.iface);
                    r.suppress = masked(shadow_via[it.entry], p) == masked(iface_addr(it.iface), p);
                    r.network  = shadow_net[it.entry];
                    r.prefix   = shadow_pfx[it.entry];
                    r.distance = shadow_dist[it.entry];
                    r.via      = shadow_via[it.entry];
                end
            dvrt_pkg::KIND_SEND:
                if (it.iface >= n)
                    r.status = dvrt_pkg::STAT_BAD_IDX;
                else if (it.ok)
                begin
                    if (shadow_link[it.iface] == dvrt_pkg::LINK_UNREACH)
                        shadow_link[it.iface] = dvrt_pkg::LINK_UNSEEN;
                end
                else
                begin
                    p    = iface_pfx(it.iface);
                    dnet = masked(iface_addr(it.iface), p);
                    shadow_link[it.iface] = dvrt_pkg::LINK_UNREACH;
                    for (int j = 0; j < shadow_count; j++)
                        if (shadow_via[j] == 32'd0 && masked(shadow_net[j], shadow_pfx[j]) == dnet)
                            shadow_dist[j] = dvrt_pkg::DIST_INF;
                end
            dvrt_pkg::KIND_SEED:
            begin
                shadow_count = 0;
                for (int i = 0; i < 4; i++)
                    shadow_link[i] = dvrt_pkg::LINK_UNSEEN;
                for (int i = 0; i < n; i++)
                begin
                    store_route(i, iface_addr(i), iface_pfx(i), iface_cost(i), 32'd0);
                    shadow_count++;
                end
            end
            default: ;
        endcase
        r.count = 7'(shadow_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and the registers' port
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: offer queued items, with a random gap after each one
    // ------------------------------------------------------------------
    initial
    begin
        in_if.valid          = 1'b0;
        in_if.kind           = '0;
        in_if.adv_network    = '0;
        in_if.adv_prefix     = '0;
        in_if.adv_distance   = '0;
        in_if.sender_address = '0;
        in_if.entry_index    = '0;
        in_if.iface_index    = '0;
        in_if.send_ok        = 1'b0;
        out_if.ready         = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
    end

    always @(negedge clk)
    begin
        route_item_t it;
        logic        next_valid;
        bit          busy;
        busy = in_if.valid;
        if (in_if.valid && in_beats != drv_seen)
        begin
            drv_seen = in_beats;
            busy     = 1'b0;
        end
        next_valid = busy;
        if (rst_n && !busy)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                next_valid = 1'b0;
            end
            else if (item_queue.size() > 0)
            begin
                it = item_queue.pop_front();
                in_if.kind           <= it.kind;
                in_if.adv_network    <= it.network;
                in_if.adv_prefix     <= it.prefix;
                in_if.adv_distance   <= it.distance;
                in_if.sender_address <= it.sender;
                in_if.entry_index    <= it.entry;
                in_if.iface_index    <= it.iface;
                in_if.send_ok        <= it.ok;
                next_valid = 1'b1;
                in_gap     = gap_free ? 0 : $urandom_range(0, 7);
            end
            else
                next_valid = 1'b0;
        end
        in_if.valid <= next_valid;
    end

    // Receiver: random stall after each beat, plus the long hold when asked.
    always @(negedge clk)
    begin
        if (out_beats != rcv_seen)
        begin
            rcv_seen  = out_beats;
            out_stall = gap_free ? 0 : $urandom_range(0, 7);
        end
        out_if.ready <= rst_n && out_stall == 0 && hold_left == 0;
        if (out_stall > 0)
            out_stall--;
    end

    // Long hold: count the stretch here, so the sender keeps offering and the
    // block backs up into its input.
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left--;
        else if (hold_req != hold_done)
        begin
            hold_done++;
            hold_left = LONG_HOLD;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each input beat, check each result beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        route_item_t   it;
        route_result_t pred;
        route_result_t got;
        route_result_t want;
        if (rst_n && in_if.valid && in_if.ready)
        begin
            it.kind     = in_if.kind;
            it.network  = in_if.adv_network;
            it.prefix   = in_if.adv_prefix;
            it.distance = in_if.adv_distance;
            it.sender   = in_if.sender_address;
            it.entry    = in_if.entry_index;
            it.iface    = in_if.iface_index;
            it.ok       = in_if.send_ok;
            kind_seen[it.kind]++;
            pred = apply_route_item(it);
            awaited_results = {awaited_results, pred};
            in_beats++;
        end
        if (rst_n && out_if.valid && out_if.ready)
        begin
            out_beats++;
            got.status   = out_if.status;
            got.suppress = out_if.suppress;
            got.network  = out_if.out_network;
            got.prefix   = out_if.out_prefix;
            got.distance = out_if.out_distance;
            got.via      = out_if.out_via;
            got.count    = out_if.route_count;
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing awaited (status %0d count %0d)",
                         $time, got.status, got.count);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (want.status == dvrt_pkg::STAT_FULL)
                    full_hits++;
                if (want.suppress)
                    suppress_hits++;
                if (got.status !== want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                end
                if (got.suppress !== want.suppress)
                begin
                    errors++;
                    $display("%0t: suppress expected %0d got %0d", $time,
                             want.suppress, got.suppress);
                end
                if (got.network !== want.network)
                begin
                    errors++;
                    $display("%0t: out_network expected %h got %h", $time,
                             want.network, got.network);
                end
                if (got.prefix !== want.prefix)
                begin
                    errors++;
                    $display("%0t: out_prefix expected %0d got %0d", $time,
                             want.prefix, got.prefix);
                end
                if (got.distance !== want.distance)
                begin
                    errors++;
                    $display("%0t: out_distance expected %0d got %0d", $time,
                             want.distance, got.distance);
                end
                if (got.via !== want.via)
                begin
                    errors++;
                    $display("%0t: out_via expected %h got %h", $time, want.via, got.via);
                end
                if (got.count !== want.count)
                begin
                    errors++;
                    $display("%0t: route_count expected %0d got %0d", $time,
                             want.count, got.count);
                end
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no beat on either side.
    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d results still awaited", $time,
                     idle_cycles, awaited_results.size());
            $display("** distance_vector_route_table_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == dvrt_pkg::REG_IF_COUNT)
            cfg_count = value[2:0];
        else
            cfg_iface[idx - dvrt_pkg::REG_IF0] = value[53:0];
    endtask

    // Hold until every item is out and every result has come back; look at
    // the rising edge, when the driver's updates have all landed.
    task automatic drain();
        do
            @(posedge clk);
        while (item_queue.size() != 0 || in_if.valid || awaited_results.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    // Append an item to the driver's pending queue.
    function automatic void queue_item(input route_item_t it);
        item_queue = {item_queue, it};
    endfunction

    function automatic route_item_t blank_item(input logic [2:0] kind);
        route_item_t it;
        it      = '{default: '0};
        it.kind = kind;
        return it;
    endfunction

    function automatic route_item_t advert(input logic [31:0] net, input logic [5:0] pfx,
                                           input logic [15:0] dist_v, input logic [31:0] from);
        route_item_t it;
        it          = blank_item(dvrt_pkg::KIND_ADV);
        it.network  = net;
        it.prefix   = pfx;
        it.distance = dist_v;
        it.sender   = from;
        return it;
    endfunction

    // Neighbour on interface i of the usual layout, from a small pool so that
    // the same next hop comes back and can poison its own routes.
    function automatic logic [31:0] neighbour(input int i);
        return {8'd10, 8'(i + 1), 8'd0, 8'($urandom_range(2, 4))};
    endfunction

    function automatic route_item_t random_item();
        route_item_t it;
        int unsigned pick;
        int unsigned n;
        n    = (ifaces_in_use() == 0) ? 1 : ifaces_in_use();
        pick = $urandom_range(0, 99);
        it   = blank_item(dvrt_pkg::KIND_ADV);
        // Noise on every field but the kind, so every bit takes both values.
        it.network  = $urandom();
        it.prefix   = 6'($urandom_range(0, 63));
        it.distance = 16'($urandom());
        it.sender   = $urandom();
        it.entry    = 6'($urandom_range(0, 63));
        it.iface    = 2'($urandom_range(0, 3));
        it.ok       = 1'($urandom_range(0, 1));
        if (pick < 45)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                // Well-formed advertisement of a network from a small pool.
                it.sender   = neighbour($urandom_range(0, n - 1));
                it.network  = $urandom_range(0, 4) == 0
                              ? {8'd10, 8'($urandom_range(1, 4)), 16'd0}
                              : {8'd172, 8'd16, 8'($urandom_range(0, 11)), 8'd0};
                it.prefix   = $urandom_range(0, 9) == 0 ? 6'($urandom_range(16, 40)) : 6'd24;
                it.distance = $urandom_range(0, 5) == 0 ? dvrt_pkg::DIST_INF
                                                        : 16'($urandom_range(0, 12));
            end
            else if ($urandom_range(0, 1) == 0)
                it.sender = iface_addr($urandom_range(0, n - 1));
        end
        else if (pick < 58)
            it.kind = dvrt_pkg::KIND_TICK;
        else if (pick < 83)
        begin
            it.kind = dvrt_pkg::KIND_QUERY;
            if ($urandom_range(0, 4) != 0)
                it.entry = 6'($urandom_range(0, shadow_count + 1));
        end
        else if (pick < 95)
            it.kind = dvrt_pkg::KIND_SEND;
        else if (pick < 98)
            it.kind = dvrt_pkg::KIND_SEED;
        else
            it.kind = 3'($urandom_range(5, 7));
        return it;
    endfunction

    task automatic configure(input logic [2:0] count, input int unsigned mode);
        logic [53:0] value;
        write_reg(dvrt_pkg::REG_IF_COUNT, {61'd0, count});
        for (int i = 0; i < 4; i++)
        begin
            case (mode)
                0: value = {16'($urandom_range(1, 20)), 6'd24, 8'd10, 8'(i + 1), 16'd1};
                1: value = 54'({$urandom(), $urandom()});
                default: value = (i == 3) ? '1 : (i == 0) ? '0
                                 : {16'($urandom_range(0, 3)), 6'd24, 8'd10, 8'(i + 1), 16'd1};
            endcase
            write_reg(dvrt_pkg::REG_IF0 + 3'(i), {10'd0, value});
        end
    endtask

    initial
    begin
        logic [2:0]  counts [8];
        int unsigned modes [8];
        for (int i = 0; i < 4; i++)
        begin
            cfg_iface[i]   = '0;
            shadow_link[i] = dvrt_pkg::LINK_UNSEEN;
        end
        cfg_count    = 3'd1;
        shadow_count = 0;
        counts = '{3'd1, 3'd2, 3'd4, 3'd3, 3'd0, 3'd7, 3'd5, 3'd4};
        modes  = '{0, 0, 0, 0, 0, 1, 2, 0};
        @(posedge rst_n);

        // Directed, on the reset registers (one interface at address 0, prefix 0).
        queue_item(blank_item(dvrt_pkg::KIND_QUERY));                 // empty table
        queue_item(advert(32'h0A00_0000, 6'd8, 16'd5, 32'h0));        // self-sent
        queue_item(blank_item(dvrt_pkg::KIND_SEED));
        queue_item(advert(32'hFFFF_FFFF, 6'd63, 16'hFFFE, 32'hFFFF_FFFF));
        queue_item(blank_item(dvrt_pkg::KIND_TICK));
        drain();

        // Directed, on the usual two-interface layout.
        configure(3'd2, 0);
        queue_item(blank_item(dvrt_pkg::KIND_SEED));
        queue_item(advert(32'hAC10_0100, 6'd24, 16'd3, 32'h0A01_0002));
        queue_item(advert(32'hAC10_0100, 6'd24, 16'd1, 32'h0A02_0002)); // relax
        queue_item(advert(32'hAC10_0100, 6'd24, dvrt_pkg::DIST_INF, 32'h0A02_0002)); // poison
        queue_item(advert(32'hAC10_0200, 6'd40, 16'hFFFE, 32'h0A01_0003)); // saturate
        queue_item(advert(32'h0A01_0000, 6'd24, 16'd0, 32'h0A02_0003));
        queue_item(advert(32'hAC10_0300, 6'd24, 16'd2, 32'h0A01_0001)); // self
        queue_item(advert(32'hAC10_0300, 6'd24, 16'd2, 32'hC0A8_0001)); // foreign
        queue_item(advert(32'hAC10_0400, 6'd24, dvrt_pkg::DIST_INF, 32'h0A01_0002)); // no append
        begin
            route_item_t it;
            it = blank_item(dvrt_pkg::KIND_QUERY);
            it.entry = 6'd2;
            it.iface = 2'd1;
            queue_item(it);
            it.iface = 2'd3;                                         // interface not in use
            queue_item(it);
            it.entry = 6'd63;
            it.iface = 2'd0;
            queue_item(it);                                          // entry out of range
            it = blank_item(dvrt_pkg::KIND_SEND);
            it.iface = 2'd0;
            queue_item(it);                                          // failed send
            queue_item(blank_item(dvrt_pkg::KIND_TICK));
            it.ok = 1'b1;
            queue_item(it);                                          // recovers
            it.iface = 2'd2;
            queue_item(it);                                          // not in use
            queue_item(blank_item(dvrt_pkg::KIND_TICK));
            queue_item(blank_item(dvrt_pkg::KIND_TICK));
            queue_item(blank_item(3'd7));                            // unknown kind
        end
        drain();

        // Fill the table from one neighbour until it reports full.
        configure(3'd1, 0);
        queue_item(blank_item(dvrt_pkg::KIND_SEED));
        for (int k = 0; k < 68; k++)
            queue_item(advert({8'd172, 8'd17, 8'(k), 8'd0}, 6'd24,
                              16'($urandom_range(0, 9)), neighbour(0)));
        for (int k = 0; k < 6; k++)
            queue_item(random_item());
        drain();

        // Random phases through several register settings.
        for (int ph = 0; ph < 8; ph++)
        begin
            configure(counts[ph], modes[ph]);
            gap_free = (ph % 3) == 2;
            queue_item(blank_item(dvrt_pkg::KIND_SEED));
            if (ph == 2)
                hold_req++;
            for (int k = 0; k < 42; k++)
                queue_item(random_item());
            drain();
        end

        // Let the last scan finish before the verdict.
        repeat (600) @(negedge clk);
        $display("Covered %0d adverts, %0d ticks, %0d queries, %0d send reports, %0d seeds.",
                 kind_seen[dvrt_pkg::KIND_ADV], kind_seen[dvrt_pkg::KIND_TICK],
                 kind_seen[dvrt_pkg::KIND_QUERY], kind_seen[dvrt_pkg::KIND_SEND],
                 kind_seen[dvrt_pkg::KIND_SEED]);
        $display("%0d results checked, %0d table-full, %0d split-horizon hits, %0d errors.",
                 out_beats, full_hits, suppress_hits, errors);
        if (errors == 0 && awaited_results.size() == 0)
            $display("** distance_vector_route_table_unit: PASSED **");
        else
            $display("** distance_vector_route_table_unit: FAILED **");
        $finish;
    end

endmodule
